// ===== rtl/core/itr_pkg.sv =====
// itr_pkg: shared types, constants and the symbol token table for the
// integer to Roman numeral converter. No dependencies.
package itr_pkg;

    localparam int ValW    = 12;
    localparam int SymW    = 8;
    localparam int NumTok  = 13;
    localparam int TokIdxW = 4;

    localparam logic [ValW-1:0] MaxValue = 12'd3999;

    // ASCII codes of the letters
    localparam logic [SymW-1:0] SymI = 8'h49;
    localparam logic [SymW-1:0] SymV = 8'h56;
    localparam logic [SymW-1:0] SymX = 8'h58;
    localparam logic [SymW-1:0] SymL = 8'h4C;
    localparam logic [SymW-1:0] SymC = 8'h43;
    localparam logic [SymW-1:0] SymD = 8'h44;
    localparam logic [SymW-1:0] SymM = 8'h4D;

    // One greedy token: its weight and one or two letters
    typedef struct packed {
        logic [ValW-1:0] weight;
        logic [SymW-1:0] sym_a;
        logic [SymW-1:0] sym_b;
        logic            pair;
    } t_tok;

    // Controller state, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_zero;
        logic out_busy;
        logic final_sym;
    } t_sts;

    // Token table, largest weight first
    function automatic t_tok tok_at(input logic [TokIdxW-1:0] idx);
        t_tok tok;
        unique case (idx)
            4'd0:    tok = '{12'd1000, SymM, SymM, 1'b0};
            4'd1:    tok = '{12'd900,  SymC, SymM, 1'b1};
            4'd2:    tok = '{12'd500,  SymD, SymD, 1'b0};
            4'd3:    tok = '{12'd400,  SymC, SymD, 1'b1};
            4'd4:    tok = '{12'd100,  SymC, SymC, 1'b0};
            4'd5:    tok = '{12'd90,   SymX, SymC, 1'b1};
            4'd6:    tok = '{12'd50,   SymL, SymL, 1'b0};
            4'd7:    tok = '{12'd40,   SymX, SymL, 1'b1};
            4'd8:    tok = '{12'd10,   SymX, SymX, 1'b0};
            4'd9:    tok = '{12'd9,    SymI, SymX, 1'b1};
            4'd10:   tok = '{12'd5,    SymV, SymV, 1'b0};
            4'd11:   tok = '{12'd4,    SymI, SymV, 1'b1};
            default: tok = '{12'd1,    SymI, SymI, 1'b0};
        endcase
        return tok;
    endfunction

endpackage

// ===== rtl/core/itr_dp.sv =====
// itr_dp: datapath of the Roman numeral converter: remainder register,
// greedy token pick, letter select and the output word register. Uses itr_pkg.
module itr_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  itr_pkg::t_cmd            i_cmd,
    output itr_pkg::t_sts            o_sts,
    input  logic [itr_pkg::ValW-1:0] i_value,
    input  logic                     i_out_ready,
    output logic                     o_valid,
    output logic [itr_pkg::SymW-1:0] o_symbol,
    output logic                     o_last
);

    logic [itr_pkg::ValW-1:0]    r_rem,    n_rem;
    logic                        r_phase,  n_phase;
    logic                        r_valid;
    logic [itr_pkg::SymW-1:0]    r_symbol;
    logic                        r_last;

    logic [itr_pkg::TokIdxW-1:0] sel;
    itr_pkg::t_tok               tok;
    logic [itr_pkg::ValW-1:0]    sat_value;
    logic [itr_pkg::SymW-1:0]    cur_sym;
    logic                        tok_done;
    logic                        cur_last;

    // Saturate the incoming integer
    assign sat_value = (i_value > itr_pkg::MaxValue) ? itr_pkg::MaxValue : i_value;

    // Pick the largest token that fits the remainder
    always_comb begin
        itr_pkg::t_tok cand;
        sel = itr_pkg::TokIdxW'(itr_pkg::NumTok - 1);
        for (int k = itr_pkg::NumTok - 1; k >= 0; k--) begin
            cand = itr_pkg::tok_at(itr_pkg::TokIdxW'(k));
            if (r_rem >= cand.weight) begin
                sel = itr_pkg::TokIdxW'(k);
            end
        end
    end

    assign tok      = itr_pkg::tok_at(sel);
    assign cur_sym  = r_phase ? tok.sym_b : tok.sym_a;
    assign tok_done = !tok.pair || r_phase;
    assign cur_last = tok_done && (r_rem == tok.weight);

    // Remainder and token phase
    always_comb begin
        n_rem   = r_rem;
        n_phase = r_phase;
        if (i_cmd.load) begin
            n_rem   = sat_value;
            n_phase = 1'b0;
        end else if (i_cmd.step) begin
            if (tok_done) begin
                n_rem   = r_rem - tok.weight;
                n_phase = 1'b0;
            end else begin
                n_phase = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_phase <= n_phase;
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_symbol <= cur_sym;
            r_last   <= cur_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;

    assign o_sts.in_zero   = (i_value == '0);
    assign o_sts.out_busy  = r_valid;
    assign o_sts.final_sym = cur_last;

    // A held word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_out_ready) |-> !i_cmd.step)
        else $error("output word overwritten while stalled");

    // Letters are only produced from a nonzero remainder
    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rem != '0))
        else $error("step with empty remainder");

    // Finishing a token strictly lowers the remainder
    a_rem_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && tok_done) |=> (r_rem < $past(r_rem)))
        else $error("remainder did not drop");

endmodule

// ===== rtl/core/itr_ctrl.sv =====
// itr_ctrl: controller of the Roman numeral converter: takes input words
// and paces letter emission. Uses itr_pkg.
module itr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_out_ready,
    input  itr_pkg::t_sts i_sts,
    output itr_pkg::t_cmd o_cmd
);

    itr_pkg::t_state r_state, n_state;
    logic            slot_free;

    assign slot_free = !i_sts.out_busy || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            itr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.in_zero) begin
                        n_state = itr_pkg::ST_EMIT;
                    end
                end
            end
            itr_pkg::ST_EMIT: begin
                if (slot_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.final_sym) begin
                        n_state = itr_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = itr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == itr_pkg::ST_IDLE);

endmodule

// ===== rtl/core/int_to_roman_numeral_top.sv =====
// int_to_roman_numeral_top: top level of the Roman numeral converter.
// Instantiates itr_ctrl and itr_dp; uses itr_pkg.
//
// Usage:
//   Input channel (i_valid/o_ready, i_value): one 12-bit unsigned integer
//   per word. Values above 3999 are clamped to 3999.
//   Output channel (o_valid/i_ready, o_symbol, o_last): one ASCII letter per
//   word, most significant place first; o_last marks the final letter.
//   A zero input is consumed and produces no output words.
// Flow:
//   A taken word is loaded into the remainder register; the first letter is
//   then written to the output register once that register is free, and the
//   rest follow one per cycle while the receiver keeps up. A numeral has at
//   most 15 letters. The emit loop produces one letter per cycle from a
//   remainder register while the output register is free or being emptied.
//   The next input is taken as soon as the final letter sits in the output
//   register, even if it has not been collected yet.
// Reset: i_rst_n, synchronous active low, returns to idle and empties the
//   output register. When the receiver stalls, the held letter stays put and
//   emission pauses until it is taken.
module int_to_roman_numeral_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [itr_pkg::ValW-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [itr_pkg::SymW-1:0] o_symbol,
    output logic                     o_last
);

    itr_pkg::t_cmd cmd;
    itr_pkg::t_sts sts;

    itr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    itr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_value     (i_value),
        .i_out_ready (i_ready),
        .o_valid     (o_valid),
        .o_symbol    (o_symbol),
        .o_last      (o_last)
    );

endmodule
